/* design/lrbcs_pkg.sv */
// Shared types and constants for the left/right best candidate selector.
// Depends on nothing; every other design file imports it.
package lrbcs_pkg;

   // Field widths
   localparam int unsigned DataW    = 16;
   localparam int unsigned CsrAddrW = 2;
   localparam int unsigned MaxCntW  = 2;

   // Batch summary queue between front and back
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

   // Register indexes on the csr port
   typedef enum logic [CsrAddrW-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_SWAP      = 2'd1,
      CSR_MAX_COUNT = 2'd2
   } csr_index_type;

   // Register reset values
   localparam logic [DataW-1:0]   ThresholdReset = 16'h8000;
   localparam logic               SwapReset      = 1'b0;
   localparam logic [MaxCntW-1:0] MaxCountReset  = 2'd2;

   // Result plan of one batch: first beat, and an optional right-side second beat
   typedef struct packed {
      logic             first_valid;
      logic [DataW-1:0] first_index;
      logic             first_left;
      logic             two;
      logic [DataW-1:0] second_index;
   } batch_sum_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic             full;
      logic             not_empty;
      logic [QCntW-1:0] level;
   } queue_status_type;

endpackage

/* design/lrbcs_chan_if.sv */
// Channel interfaces of the selector: candidate input and selection output.
// Depends on lrbcs_pkg for field widths.
interface lrbcs_req_if import lrbcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DataW-1:0] cand_index;
   logic [DataW-1:0] cand_confidence;
   logic [DataW-1:0] hand_score;
   logic             batch_last;

   modport source (output valid, cand_index, cand_confidence, hand_score, batch_last,
                   input ready);
   modport sink   (input valid, cand_index, cand_confidence, hand_score, batch_last,
                   output ready);
endinterface

interface lrbcs_rsp_if import lrbcs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             sel_valid;
   logic [DataW-1:0] sel_index;
   logic             is_left;
   logic             sel_last;

   modport source (output valid, sel_valid, sel_index, is_left, sel_last, input ready);
   modport sink   (input valid, sel_valid, sel_index, is_left, sel_last, output ready);
endinterface

/* design/left_right_best_candidate_select.sv */
// Top level of the left/right best candidate selector.
// Depends on lrbcs_pkg, lrbcs_chan_if, lrbcs_front, lrbcs_fifo and lrbcs_back.
//
// Usage:
//   req_bus carries one candidate per beat (index, confidence, hand score,
//   batch_last). Beats are taken back to back while the queue has room. Beats without
//   batch_last produce nothing; the batch_last beat produces one or two beats
//   on rsp_bus: left pick first, then right, the final one with sel_last set.
//   A batch with no pick (or max_count zero) yields one beat with sel_valid 0.
//   The finished plan is written into a two-entry plan queue and then loaded
//   into the registered output stage before it is presented on rsp_bus.
//   rsp_bus sustains one beat per cycle while ready is high, so a two-result
//   batch occupies the output for two beats.
//   If rsp_bus stalls, the output register holds its beat while the queue
//   absorbs up to two finished batches; req_bus.ready drops only when both
//   queue entries are taken. Reset (synchronous) clears stored picks, the
//   queue and the output stage, and loads threshold 32768, no swap, max two.
//   csr writes take effect at once and are meant for idle periods.
module left_right_best_candidate_select import lrbcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   lrbcs_req_if.sink           req_bus,
   lrbcs_rsp_if.source         rsp_bus,
   input  logic                csr_wr_en,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [DataW-1:0]    csr_wdata
);

   queue_status_type q_status;
   batch_sum_type    q_data;
   batch_sum_type    q_head;
   logic             q_push;
   logic             q_pop;
   logic             pending;

   lrbcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   lrbcs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .status    (q_status),
      .head      (q_head)
   );

   lrbcs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .pending  (pending),
      .rsp_bus  (rsp_bus)
   );

   // A two-beat plan always starts with a real selection
   a_two_has_first: assert property (@(posedge clock) disable iff (reset)
      q_push && q_data.two |-> q_data.first_valid)
      else $error("two-beat plan without a first selection");

   // The empty-batch marker is always the final beat of its batch
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.sel_valid |-> rsp_bus.sel_last)
      else $error("marker beat without sel_last");

   // A pending second beat means the first beat is still on the output
   a_pending_shown: assert property (@(posedge clock) disable iff (reset)
      pending |-> rsp_bus.valid && !rsp_bus.sel_last)
      else $error("second beat pending without a first beat shown");

   // Queue level stays in range
   a_queue_level: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= QCntW'(QueueDepth))
      else $error("plan queue level out of range");

endmodule

/* design/lrbcs_front.sv */
// Front end: config registers, per-side thresholding and best-pick tracking.
// On a batch's last beat it pushes a result plan into the queue. Uses lrbcs_pkg.
module lrbcs_front import lrbcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   lrbcs_req_if.sink           req_bus,
   input  logic                csr_wr_en,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [DataW-1:0]    csr_wdata,
   input  queue_status_type    q_status,
   output logic                q_push,
   output batch_sum_type       q_data
);

   // Config registers
   logic [DataW-1:0]   thr_ff;
   logic               swap_ff;
   logic [MaxCntW-1:0] maxc_ff;

   // Stored picks
   logic             l_have_ff, l_have_in;
   logic [DataW-1:0] l_idx_ff, l_idx_in;
   logic [DataW-1:0] l_conf_ff, l_conf_in;
   logic [DataW-1:0] l_sc_ff, l_sc_in;
   logic             r_have_ff, r_have_in;
   logic [DataW-1:0] r_idx_ff, r_idx_in;
   logic [DataW-1:0] r_conf_ff, r_conf_in;
   logic [DataW-1:0] r_sc_ff, r_sc_in;

   logic             accept;
   logic [DataW-1:0] ls, rs;
   logic             l_take, r_take;
   logic             dup, emit_l, emit_r, use_l0, use_r0;

   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= ThresholdReset;
         swap_ff <= SwapReset;
         maxc_ff <= MaxCountReset;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_THRESHOLD: thr_ff  <= csr_wdata;
            CSR_SWAP:      swap_ff <= csr_wdata[0];
            CSR_MAX_COUNT: maxc_ff <= csr_wdata[MaxCntW-1:0];
            default: ;
         endcase
      end
   end

   // Side scores: without swap, right is the complement of the raw score (65535 - x); swap exchanges them
   always_comb begin
      ls = swap_ff ? ~req_bus.hand_score : req_bus.hand_score;
      rs = swap_ff ? req_bus.hand_score : ~req_bus.hand_score;
   end

   // Keep the higher confidence; earlier beat wins a tie
   always_comb begin
      l_take = (ls > thr_ff) && (!l_have_ff || (req_bus.cand_confidence > l_conf_ff));
      r_take = (rs > thr_ff) && (!r_have_ff || (req_bus.cand_confidence > r_conf_ff));

      l_have_in = l_have_ff || l_take;
      l_idx_in  = l_take ? req_bus.cand_index      : l_idx_ff;
      l_conf_in = l_take ? req_bus.cand_confidence : l_conf_ff;
      l_sc_in   = l_take ? ls                      : l_sc_ff;
      r_have_in = r_have_ff || r_take;
      r_idx_in  = r_take ? req_bus.cand_index      : r_idx_ff;
      r_conf_in = r_take ? req_bus.cand_confidence : r_conf_ff;
      r_sc_in   = r_take ? rs                      : r_sc_ff;
   end

   // Result plan for the batch, built from the updated picks
   always_comb begin
      dup    = l_have_in && r_have_in && (l_idx_in == r_idx_in);
      emit_l = l_have_in && !(dup && (l_sc_in < r_sc_in));
      emit_r = r_have_in && !(dup && (l_sc_in >= r_sc_in));
      use_l0 = (maxc_ff != '0) && emit_l;
      use_r0 = (maxc_ff != '0) && !emit_l && emit_r;

      q_data.first_valid  = use_l0 || use_r0;
      q_data.first_index  = use_l0 ? l_idx_in : (use_r0 ? r_idx_in : '0);
      q_data.first_left   = use_l0;
      q_data.two          = (maxc_ff >= MaxCntW'(2)) && emit_l && emit_r;
      q_data.second_index = r_idx_in;
      q_push              = accept && req_bus.batch_last;
   end

   // Pick flags: cleared at reset and after each batch
   always_ff @(posedge clock) begin
      if (reset) begin
         l_have_ff <= 1'b0;
         r_have_ff <= 1'b0;
      end else if (accept) begin
         l_have_ff <= l_have_in && !req_bus.batch_last;
         r_have_ff <= r_have_in && !req_bus.batch_last;
      end
   end

   // Pick payload, only read while its flag is set
   always_ff @(posedge clock) begin
      if (accept) begin
         l_idx_ff  <= l_idx_in;
         l_conf_ff <= l_conf_in;
         l_sc_ff   <= l_sc_in;
         r_idx_ff  <= r_idx_in;
         r_conf_ff <= r_conf_in;
         r_sc_ff   <= r_sc_in;
      end
   end

endmodule

/* design/lrbcs_fifo.sv */
// Short queue of batch result plans between front and back.
// Flop-based, one push and one pop per cycle. Uses lrbcs_pkg.
module lrbcs_fifo import lrbcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  batch_sum_type    push_data,
   input  logic             pop,
   output queue_status_type status,
   output batch_sum_type    head
);

   batch_sum_type    mem_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] level_ff, level_in;

   assign status.full      = (level_ff == QCntW'(QueueDepth));
   assign status.not_empty = (level_ff != '0);
   assign status.level     = level_ff;
   assign head             = mem_ff[rd_ptr_ff];

   // Pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + QCntW'(1);
      end else if (pop && !push) begin
         level_in = level_ff - QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/lrbcs_back.sv */
// Back end: turns queued result plans into one or two output beats
// through a registered output stage. Uses lrbcs_pkg and lrbcs_rsp_if.
module lrbcs_back import lrbcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  batch_sum_type    q_head,
   output logic             q_pop,
   output logic             pending,
   lrbcs_rsp_if.source      rsp_bus
);

   logic             out_valid_ff;
   logic             out_sel_valid_ff;
   logic [DataW-1:0] out_index_ff;
   logic             out_left_ff;
   logic             out_last_ff;
   logic             pend_ff;
   logic [DataW-1:0] pend_index_ff;
   logic             load;

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.sel_valid = out_sel_valid_ff;
   assign rsp_bus.sel_index = out_index_ff;
   assign rsp_bus.is_left   = out_left_ff;
   assign rsp_bus.sel_last  = out_last_ff;
   assign pending           = pend_ff;

   // Output stage free when empty or being taken this cycle
   assign load  = !out_valid_ff || rsp_bus.ready;
   assign q_pop = load && !pend_ff && q_status.not_empty;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else if (load) begin
         if (pend_ff) begin
            out_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
         end else begin
            out_valid_ff <= q_status.not_empty;
            pend_ff      <= q_status.not_empty && q_head.two;
         end
      end
   end

   // Beat payload: second beat is always the right-side pick and ends the batch
   always_ff @(posedge clock) begin
      if (load) begin
         if (pend_ff) begin
            out_sel_valid_ff <= 1'b1;
            out_index_ff     <= pend_index_ff;
            out_left_ff      <= 1'b0;
            out_last_ff      <= 1'b1;
         end else begin
            out_sel_valid_ff <= q_head.first_valid;
            out_index_ff     <= q_head.first_index;
            out_left_ff      <= q_head.first_left;
            out_last_ff      <= !q_head.two;
            pend_index_ff    <= q_head.second_index;
         end
      end
   end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for left_right_best_candidate_select: random and directed
// candidate batches, a tracking pick model and an in-order selection scoreboard.
// Depends on lrbcs_pkg, lrbcs_chan_if and the design sources.
`timescale 1ns / 1ps

module tb_top;
   import lrbcs_pkg::*;

   localparam int CycleLimit  = 1000000;
   localparam int DrainCycles = 8;
   localparam int HoldCycles  = 300;

   typedef struct packed {
      logic [DataW-1:0] idx;
      logic [DataW-1:0] conf;
      logic [DataW-1:0] hand;
      logic             last;
   } candidate_type;

   typedef struct packed {
      logic             have;
      logic [DataW-1:0] idx;
      logic [DataW-1:0] conf;
      logic [DataW-1:0] score;
   } pick_type;

   typedef struct packed {
      logic             sel_valid;
      logic [DataW-1:0] sel_index;
      logic             is_left;
      logic             sel_last;
   } selection_type;

   logic clock;
   logic reset;
   logic                csr_wr_en;
   logic [CsrAddrW-1:0] csr_addr;
   logic [DataW-1:0]    csr_wdata;

   lrbcs_req_if req_bus ();
   lrbcs_rsp_if rsp_bus ();

   left_right_best_candidate_select u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Bench copy of the registers and of the per-side picks
   logic [DataW-1:0]   cfg_thr;
   logic               cfg_swap;
   logic [MaxCntW-1:0] cfg_max;
   pick_type           left_pick;
   pick_type           right_pick;

   candidate_type pending_cands[$];
   selection_type expected_sels[$];
   candidate_type drv_cur;

   int  drv_gap;
   int  mon_gap;
   bit  drv_burst;
   bit  mon_burst;
   bit  force_burst;
   bit  pressure_arm;
   bit  pressure_taken;
   int  hold_cnt;

   int  cycle_count;
   int  items_accepted;
   int  batches_closed;
   int  beats_checked;
   int  mismatch_count;
   int  csr_writes;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Append to the tail of the scoreboard and of the stimulus queue
   function automatic void add_expected(input selection_type s);
      expected_sels.insert(expected_sels.size(), s);
   endfunction

   function automatic void add_pending(input candidate_type c);
      pending_cands.insert(pending_cands.size(), c);
   endfunction

   // Keep the better candidate for one side; ties leave the earlier one
   function automatic pick_type offered(pick_type p, candidate_type c, logic [DataW-1:0] s);
      pick_type q;
      q = p;
      if (!p.have || c.conf > p.conf) begin
         q.have  = 1'b1;
         q.idx   = c.idx;
         q.conf  = c.conf;
         q.score = s;
      end
      return q;
   endfunction

   // Update picks with one accepted candidate; on batch_last queue the selections
   task automatic predict_selection(input candidate_type c);
      logic [DataW-1:0] ls, rs, t;
      bit take_l, take_r, emit_l, emit_r;
      ls = c.hand;
      rs = 16'hFFFF - c.hand;
      if (cfg_swap) begin
         t  = ls;
         ls = rs;
         rs = t;
      end
      if (ls > cfg_thr) left_pick = offered(left_pick, c, ls);
      if (rs > cfg_thr) right_pick = offered(right_pick, c, rs);
      if (c.last) begin
         take_l = left_pick.have;
         take_r = right_pick.have;
         // same index on both sides: higher side score keeps it, left on a tie
         if (take_l && take_r && left_pick.idx == right_pick.idx) begin
            if (left_pick.score >= right_pick.score) take_r = 1'b0;
            else take_l = 1'b0;
         end
         emit_l = take_l && (cfg_max >= 1);
         emit_r = take_r && (emit_l ? (cfg_max >= 2) : (cfg_max >= 1));
         if (emit_l) add_expected({1'b1, left_pick.idx, 1'b1, !emit_r});
         if (emit_r) add_expected({1'b1, right_pick.idx, 1'b0, 1'b1});
         if (!emit_l && !emit_r) add_expected({1'b0, 16'h0000, 1'b0, 1'b1});
         left_pick  = '0;
         right_pick = '0;
         batches_closed++;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                  input logic [DataW-1:0] want);
      mismatch_count++;
      $display("ERROR at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
   endtask

   // Sender: one candidate beat at a time, random gap drawn after each accept
   always @(posedge clock) begin : drive_req
      bit fire;
      if (reset) begin
         req_bus.valid <= 1'b0;
         drv_gap = 0;
      end else begin
         fire = req_bus.valid && req_bus.ready;
         if (fire) begin
            predict_selection(drv_cur);
            items_accepted++;
            if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
            drv_gap = (drv_burst || force_burst) ? 0 : $urandom_range(0, 19);
         end
         if (req_bus.valid && !fire) begin
            // hold the offered beat
         end else if (drv_gap > 0) begin
            drv_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_cands.size() > 0) begin
            drv_cur = pending_cands.pop_front();
            req_bus.cand_index      <= drv_cur.idx;
            req_bus.cand_confidence <= drv_cur.conf;
            req_bus.hand_score      <= drv_cur.hand;
            req_bus.batch_last      <= drv_cur.last;
            req_bus.valid           <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // One long receiver hold-off, started once the pressure phase arms it
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
      end else if (pressure_arm && !pressure_taken) begin
         hold_cnt       <= HoldCycles;
         pressure_taken <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   // Receiver: check each selection beat against the oldest expectation
   always @(posedge clock) begin : watch_rsp
      bit fire;
      selection_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         mon_gap = 0;
      end else begin
         fire = rsp_bus.valid && rsp_bus.ready;
         if (fire) begin
            beats_checked++;
            if (expected_sels.size() == 0) begin
               report_mismatch("beat with nothing expected, index", rsp_bus.sel_index, '0);
            end else begin
               want = expected_sels.pop_front();
               if (rsp_bus.sel_valid !== want.sel_valid)
                  report_mismatch("sel_valid", DataW'(rsp_bus.sel_valid),
                                  DataW'(want.sel_valid));
               if (rsp_bus.sel_index !== want.sel_index)
                  report_mismatch("sel_index", rsp_bus.sel_index, want.sel_index);
               if (rsp_bus.is_left !== want.is_left)
                  report_mismatch("is_left", DataW'(rsp_bus.is_left), DataW'(want.is_left));
               if (rsp_bus.sel_last !== want.sel_last)
                  report_mismatch("sel_last", DataW'(rsp_bus.sel_last),
                                  DataW'(want.sel_last));
            end
            if ($urandom_range(0, 39) == 0) mon_burst = !mon_burst;
            mon_gap = mon_burst ? 0 : $urandom_range(0, 19);
         end else if (mon_gap > 0) begin
            mon_gap--;
         end
         rsp_bus.ready <= (mon_gap == 0) && (hold_cnt == 0);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timed out after %0d cycles, %0d selections outstanding",
                  cycle_count, expected_sels.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_csr(input csr_index_type which, input logic [DataW-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= which;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (which)
         CSR_THRESHOLD: cfg_thr  = value;
         CSR_SWAP:      cfg_swap = value[0];
         CSR_MAX_COUNT: cfg_max  = value[MaxCntW-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic push_cand(input logic [DataW-1:0] idx, input logic [DataW-1:0] conf,
                            input logic [DataW-1:0] hand, input logic last);
      add_pending({idx, conf, hand, last});
   endtask

   // Wait for the block to go quiet before touching registers
   task automatic settle();
      while (!(pending_cands.size() == 0 && !req_bus.valid && expected_sels.size() == 0))
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Random candidate, biased to both thresholds, ties and shared indexes
   function automatic candidate_type random_cand(input logic last);
      candidate_type c;
      logic [DataW-1:0] near;
      near = DataW'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
         0:       c.idx = DataW'($urandom_range(0, 3));
         1:       c.idx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: c.idx = DataW'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0:       c.conf = 16'h0000;
         1:       c.conf = 16'hFFFF;
         2:       c.conf = 16'h1000 + DataW'($urandom_range(0, 2));
         default: c.conf = DataW'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       c.hand = cfg_thr + near - 16'd1;
         1:       c.hand = 16'hFFFF - cfg_thr + near - 16'd1;
         2:       c.hand = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: c.hand = DataW'($urandom);
      endcase
      c.last = last;
      return c;
   endfunction

   // Queue whole batches until about n_items are waiting
   task automatic queue_batches(input int n_items, input int max_len);
      int count, len;
      count = 0;
      while (count < n_items) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 24)
                                            : $urandom_range(1, max_len);
         for (int k = 0; k < len; k++) add_pending(random_cand(k == len - 1));
         count += len;
      end
   endtask

   // Main sequence
   initial begin : main_seq
      logic [DataW-1:0] thr;
      int sel;
      reset     = 1'b1;
      csr_wr_en = 1'b0;
      csr_addr  = '0;
      csr_wdata = '0;
      req_bus.valid           = 1'b0;
      req_bus.cand_index      = '0;
      req_bus.cand_confidence = '0;
      req_bus.hand_score      = '0;
      req_bus.batch_last      = 1'b0;
      rsp_bus.ready           = 1'b0;
      cfg_thr  = ThresholdReset;
      cfg_swap = SwapReset;
      cfg_max  = MaxCountReset;
      left_pick  = '0;
      right_pick = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: side extremes, threshold edge, ties, shared index
      push_cand(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
      push_cand(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
      push_cand(16'h1234, 16'd500, 16'h8000, 1'b1);
      push_cand(16'h0042, 16'd1, 16'h8001, 1'b1);
      push_cand(16'd10, 16'd700, 16'hF000, 1'b0);
      push_cand(16'd11, 16'd700, 16'hF000, 1'b0);
      push_cand(16'd12, 16'd699, 16'hF000, 1'b0);
      push_cand(16'd20, 16'd300, 16'h0100, 1'b1);
      push_cand(16'd5, 16'd900, 16'd60000, 1'b0);
      push_cand(16'd5, 16'd800, 16'd1000, 1'b1);
      push_cand(16'd7, 16'd1, 16'd40000, 1'b0);
      push_cand(16'd7, 16'd2, 16'd25535, 1'b1);
      settle();

      // Threshold zero: a mid-scale hand score passes on both sides
      write_csr(CSR_THRESHOLD, 16'h0000);
      push_cand(16'd100, 16'hFFFF, 16'h0000, 1'b0);
      push_cand(16'd101, 16'h0000, 16'h7FFF, 1'b1);
      push_cand(16'd102, 16'd5, 16'h7FFF, 1'b1);
      settle();

      // Threshold at full scale: nothing can pass
      write_csr(CSR_THRESHOLD, 16'hFFFF);
      push_cand(16'd1, 16'hFFFF, 16'hFFFF, 1'b1);
      settle();

      // Max count zero, then one
      write_csr(CSR_THRESHOLD, 16'h8000);
      write_csr(CSR_MAX_COUNT, 16'd0);
      push_cand(16'd3, 16'd3, 16'hFFFF, 1'b0);
      push_cand(16'd4, 16'd4, 16'h0000, 1'b1);
      settle();
      write_csr(CSR_MAX_COUNT, 16'd1);
      push_cand(16'd3, 16'd3, 16'hFFFF, 1'b0);
      push_cand(16'd4, 16'd4, 16'h0000, 1'b1);
      settle();

      // Swapped sides, then max count three
      write_csr(CSR_SWAP, 16'd1);
      write_csr(CSR_MAX_COUNT, 16'd2);
      push_cand(16'd8, 16'd8, 16'hFFFF, 1'b1);
      settle();
      write_csr(CSR_MAX_COUNT, 16'd3);
      push_cand(16'd9, 16'd9, 16'hFFFF, 1'b0);
      push_cand(16'd10, 16'd10, 16'h0000, 1'b1);
      settle();

      // Random phases, each under its own register setting
      for (int ph = 0; ph < 13; ph++) begin
         if (ph == 0) thr = 16'h0000;
         else if (ph == 1) thr = 16'hFFFF;
         else begin
            case ($urandom_range(0, 5))
               0:       thr = 16'h0000;
               1:       thr = 16'hFFFF;
               2:       thr = 16'h8000;
               3:       thr = DataW'($urandom_range(0, 255));
               4:       thr = 16'hFFFF - DataW'($urandom_range(0, 255));
               default: thr = DataW'($urandom);
            endcase
         end
         write_csr(CSR_THRESHOLD, thr);
         write_csr(CSR_SWAP, DataW'($urandom_range(0, 1)));
         sel = $urandom_range(0, 7);
         write_csr(CSR_MAX_COUNT,
                   DataW'((sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 3 : 2));
         if (ph == 6) begin
            // Short batches back to back while the receiver holds off
            force_burst  = 1'b1;
            pressure_arm = 1'b1;
            queue_batches(150, 2);
            settle();
            force_burst = 1'b0;
         end else begin
            queue_batches(150, (ph % 3 == 0) ? 12 : 5);
            settle();
         end
      end

      $display("Ran %0d candidates in %0d batches; %0d selection beats checked",
               items_accepted, batches_closed, beats_checked);
      $display("%0d register writes: threshold extremes, both swap states, max count 0..3",
               csr_writes);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
design/lrbcs_pkg.sv
design/lrbcs_chan_if.sv
design/lrbcs_front.sv
design/lrbcs_fifo.sv
design/lrbcs_back.sv
design/left_right_best_candidate_select.sv
bench/tb_top.sv
